FILE: sv/priority_ready_queue_scheduler_defines.svh
// Assertion macros for the priority ready queue scheduler.
// Used by the top level; no other dependencies.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is active.
`define PRQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is active.
`define PRQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PRQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PRQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: sv/prqs_pkg.sv
// Shared types and codes of the priority ready queue scheduler.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package prqs_pkg;

	localparam int LEVELS      = 3;
	localparam int TASK_PORT_W = 8;
	localparam int PRI_W       = 2;
	localparam int STATUS_W    = 3;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_SCHED = 1'b1;

	localparam logic [PRI_W-1:0] PRI_IDLE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SCHED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONE    = 3'd4;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [TASK_PORT_W-1:0] running_task;
		logic                   running_valid;
		logic                   switched;
	} res_t;

endpackage

`default_nettype wire

FILE: sv/prqs_req_if.sv
// Request channel of the scheduler: valid, ready and one request item.
// Depends on prqs_pkg.
`default_nettype none

interface prqs_req_if import prqs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   op;
	logic [TASK_PORT_W-1:0] task_id;
	logic [PRI_W-1:0]       priority_req;

	modport source (output valid, op, task_id, priority_req, input ready);
	modport sink (input valid, op, task_id, priority_req, output ready);
endinterface

`default_nettype wire

FILE: sv/prqs_rsp_if.sv
// Result channel of the scheduler: valid, ready and one result item.
// Depends on prqs_pkg.
`default_nettype none

interface prqs_rsp_if import prqs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [TASK_PORT_W-1:0] running_task;
	logic                   running_valid;
	logic                   switched;

	modport source (output valid, status, running_task, running_valid, switched, input ready);
	modport sink (input valid, status, running_task, running_valid, switched, output ready);
endinterface

`default_nettype wire

FILE: sv/prqs_ready_mem.sv
// Ready-queue task store: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module prqs_ready_mem #(
	parameter int DEPTH = 24,
	parameter int WIDTH = 8
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/priority_ready_queue_scheduler.sv
// Top level of the priority ready queue scheduler.
// Depends on prqs_pkg, prqs_req_if, prqs_rsp_if, prqs_ready_mem and the defines header.
`default_nettype none
`include "priority_ready_queue_scheduler_defines.svh"

// The scheduler keeps three FIFO ready queues (high, medium, low) of QUEUE_DEPTH task
// ids each in one synchronous memory, plus an idle-task register and a running-task
// register. Every request transfer yields exactly one result transfer, in order. An
// add request is handled in the cycle of its transfer: the task id is written at the
// tail of its level's queue (or dropped when that queue is full), or it replaces the
// idle task. For a schedule request, the head of the highest non-empty queue is read
// from the memory in the transfer cycle, and the result is formed from the read data
// in the next cycle, falling back to the idle task when all queues are empty. As the
// task store's read data is registered, the request side is not ready while a
// schedule's read is in flight; adds sustain one per cycle while no result is held.
// Results sit in an output register; if it is still occupied when a result is ready,
// the result waits in a hold register and the request side pauses until it moves
// on. Task ids keep only their low TASK_ID_BITS bits. The task store is not cleared
// after reset, since the queue counts guard every read.

module priority_ready_queue_scheduler import prqs_pkg::*; #(
	parameter int QUEUE_DEPTH  = 8,
	parameter int TASK_ID_BITS = 8
) (
	input wire         clk,
	input wire         arst_n,
	prqs_req_if.sink   req,
	prqs_rsp_if.source rsp
);

	localparam int IDW   = TASK_ID_BITS;
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int HW    = $clog2(QUEUE_DEPTH);
	localparam int SW    = $clog2(2 * QUEUE_DEPTH);
	localparam int MDEP  = LEVELS * QUEUE_DEPTH;
	localparam int AW    = $clog2(MDEP);
	localparam int LVL_W = $clog2(LEVELS);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	// Narrows or widens an internal task id to the port width.
	function automatic logic [TASK_PORT_W-1:0] to_port(input logic [IDW-1:0] v);
		logic [IDW+TASK_PORT_W-1:0] e;
		e = {{TASK_PORT_W{1'b0}}, v};
		return e[TASK_PORT_W-1:0];
	endfunction

	state_t           state_q;
	logic [HW-1:0]    heads_q [LEVELS];
	logic [CW-1:0]    counts_q [LEVELS];
	logic [IDW-1:0]   running_q;
	logic             running_flag_q;
	logic [IDW-1:0]   idle_q;
	logic             idle_flag_q;
	logic             pop_s1;
	logic             out_valid_q;
	res_t             out_q;
	res_t             hold_q;

	logic                 in_xfer;
	logic                 out_free;
	logic [IDW+TASK_PORT_W-1:0] id_ext;
	logic [IDW-1:0]       add_id;
	logic [HW-1:0]        add_head;
	logic [CW-1:0]        add_cnt;
	logic                 add_full;
	logic [SW-1:0]        tail_sum;
	logic [HW-1:0]        tail_slot;
	logic                 pop_hit;
	logic [LVL_W-1:0]     pop_lvl;
	logic [HW-1:0]        pop_head;
	logic                 do_push;
	logic                 do_pop;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [IDW-1:0]       mem_rdata;
	logic [IDW-1:0]       nxt_id;
	logic                 avail;
	logic                 sw;
	res_t                 add_res;
	res_t                 sched_res;
	res_t                 cur_res;
	logic                 res_valid;

	assign in_xfer  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || rsp.ready;

	assign id_ext = {{IDW{1'b0}}, req.task_id};
	assign add_id = id_ext[IDW-1:0];

	// Queue state of the level an add request names, and the level a schedule pops.
	always_comb begin
		add_head = '0;
		add_cnt  = '0;
		pop_hit  = 1'b0;
		pop_lvl  = '0;
		pop_head = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (PRI_W'(l) == req.priority_req) begin
				add_head = heads_q[l];
				add_cnt  = counts_q[l];
			end
			if (!pop_hit && counts_q[l] != '0) begin
				pop_hit  = 1'b1;
				pop_lvl  = LVL_W'(l);
				pop_head = heads_q[l];
			end
		end
	end

	// Tail slot is head plus count, wrapped once around the queue depth.
	always_comb begin
		tail_sum = SW'(add_head) + SW'(add_cnt);
		if (tail_sum >= SW'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - SW'(QUEUE_DEPTH);
		end
		tail_slot = tail_sum[HW-1:0];
	end

	assign add_full = (add_cnt == CW'(QUEUE_DEPTH));
	assign do_push  = in_xfer && req.op == OP_ADD && req.priority_req != PRI_IDLE && !add_full;
	assign do_pop   = in_xfer && req.op == OP_SCHED && pop_hit;

	assign mem_we    = do_push;
	assign mem_waddr = AW'(req.priority_req) * AW'(QUEUE_DEPTH) + AW'(tail_slot);
	assign mem_re    = do_pop;
	assign mem_raddr = AW'(pop_lvl) * AW'(QUEUE_DEPTH) + AW'(pop_head);

	prqs_ready_mem #(
		.DEPTH (MDEP),
		.WIDTH (IDW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (add_id),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Result of an add request, formed in its transfer cycle.
	always_comb begin
		add_res.running_task  = to_port(running_q);
		add_res.running_valid = running_flag_q;
		add_res.switched      = 1'b0;
		if (req.priority_req == PRI_IDLE) begin
			add_res.status = ST_IDLE;
		end else if (add_full) begin
			add_res.status = ST_DROPPED;
		end else begin
			add_res.status = ST_QUEUED;
		end
	end

	// Result of a schedule request, formed in the cycle after its transfer, when the
	// popped task id arrives from the memory. Nothing else changes in between.
	assign nxt_id = pop_s1 ? mem_rdata : idle_q;
	assign avail  = pop_s1 || idle_flag_q;
	assign sw     = avail && (!running_flag_q || running_q != nxt_id);

	always_comb begin
		sched_res.status        = avail ? ST_SCHED : ST_NONE;
		sched_res.running_task  = to_port(avail ? nxt_id : running_q);
		sched_res.running_valid = running_flag_q || avail;
		sched_res.switched      = sw;
	end

	assign res_valid = (state_q == S_READ) || (in_xfer && req.op == OP_ADD);
	assign cur_res   = (state_q == S_READ) ? sched_res : add_res;

	// Control state and scheduler registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			running_q      <= '0;
			running_flag_q <= 1'b0;
			idle_q         <= '0;
			idle_flag_q    <= 1'b0;
			pop_s1         <= 1'b0;
			out_valid_q    <= 1'b0;
			for (int l = 0; l < LEVELS; l++) begin
				heads_q[l]  <= '0;
				counts_q[l] <= '0;
			end
		end else begin
			for (int l = 0; l < LEVELS; l++) begin
				if (do_push && PRI_W'(l) == req.priority_req) begin
					counts_q[l] <= counts_q[l] + CW'(1);
				end
				if (do_pop && LVL_W'(l) == pop_lvl) begin
					counts_q[l] <= counts_q[l] - CW'(1);
					heads_q[l]  <= (heads_q[l] == HW'(QUEUE_DEPTH - 1)) ?
						'0 : heads_q[l] + HW'(1);
				end
			end

			if (in_xfer && req.op == OP_ADD && req.priority_req == PRI_IDLE) begin
				idle_q      <= add_id;
				idle_flag_q <= 1'b1;
			end

			if (in_xfer && req.op == OP_SCHED) begin
				pop_s1 <= pop_hit;
			end

			if (state_q == S_READ && avail) begin
				running_q      <= nxt_id;
				running_flag_q <= 1'b1;
			end

			// Output register: loads a fresh or held result, else empties on transfer.
			if ((res_valid || state_q == S_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer && req.op == OP_SCHED) begin
						state_q <= S_READ;
					end else if (in_xfer && !out_free) begin
						state_q <= S_HOLD;
					end
				end
				S_READ: begin
					state_q <= out_free ? S_IDLE : S_HOLD;
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_HOLD && out_free) begin
			out_q <= hold_q;
		end else if (res_valid && out_free) begin
			out_q <= cur_res;
		end
		if (res_valid && !out_free) begin
			hold_q <= cur_res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.running_task  = out_q.running_task;
	assign rsp.running_valid = out_q.running_valid;
	assign rsp.switched      = out_q.switched;

	// A schedule transfer always moves to the read state to wait for the task store.
	`PRQS_ASSERT_NXT(a_sched_read, clk, arst_n, in_xfer && req.op == OP_SCHED, state_q == S_READ, "schedule did not enter read state")
	// A held result implies the output register is occupied.
	`PRQS_ASSERT_IMP(a_hold_busy, clk, arst_n, state_q == S_HOLD, out_valid_q, "result held with free output register")
	// Once a task has been selected to run, the flag never clears.
	`PRQS_ASSERT_IMP(a_run_sticky, clk, arst_n, 1'b1, !$fell(running_flag_q), "running flag cleared")
	// A push never lands on a full queue.
	`PRQS_ASSERT_IMP(a_push_room, clk, arst_n, mem_we, add_cnt < CW'(QUEUE_DEPTH), "push into a full queue")

endmodule

`default_nettype wire

FILE: tb/priority_ready_queue_scheduler_tb.sv
// Self-checking testbench for the priority ready queue scheduler: directed table, then random traffic.
// Depends on prqs_pkg, prqs_req_if, prqs_rsp_if and the scheduler top level; reads no files.
`default_nettype none

module priority_ready_queue_scheduler_tb;
	import prqs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH  = 8;
	localparam int TASK_ID_BITS = 8;

	// The package names only the idle level, so the three queue levels are named here.
	localparam logic [PRI_W-1:0] PRI_HIGH = 2'd0;
	localparam logic [PRI_W-1:0] PRI_MED  = 2'd1;
	localparam logic [PRI_W-1:0] PRI_LOW  = 2'd2;

	localparam int DIR_ROWS       = 25;
	localparam int ITEMS_PER_MODE = 332;
	localparam int MAX_REPORTS    = 10;

	// One row of the directed table. When typed is set, exp is the result to expect and
	// it replaces the scheduler model's figure for that transfer.
	typedef struct packed {
		logic                   op;
		logic [TASK_PORT_W-1:0] task_id;
		logic [PRI_W-1:0]       pri;
		logic                   typed;
		res_t                   exp;
	} dir_row_t;

	logic clk;
	logic arst_n;

	prqs_req_if req_ch ();
	prqs_rsp_if rsp_ch ();

	priority_ready_queue_scheduler #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TASK_ID_BITS(TASK_ID_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Side information that travels with each request, so that the monitor knows
	// whether a typed result from the table goes with the transfer it sees.
	logic req_typed;
	res_t req_typed_res;

	// Idling controls, changed by the stimulus process between traffic modes.
	int unsigned req_gap_pct;
	int unsigned rsp_stall_pct;

	// Model of the scheduler: the three ready FIFOs, the running and the idle register.
	logic [TASK_PORT_W-1:0] ready_fifo [LEVELS][QUEUE_DEPTH];
	int unsigned            fifo_head [LEVELS];
	int unsigned            fifo_fill [LEVELS];
	logic [TASK_PORT_W-1:0] run_id;
	logic                   run_flag;
	logic [TASK_PORT_W-1:0] idle_task;
	logic                   idle_flag;

	// Results the scheduler still owes, oldest first.
	res_t owed_results [$];

	int unsigned requests_sent;
	int unsigned results_seen;
	int unsigned mismatches;
	int unsigned cnt_queued, cnt_idle, cnt_dropped, cnt_sched, cnt_none, cnt_switch;

	// The directed table. It starts from reset, so the early rows can be read off by hand:
	// nothing runnable, setting and replacing the idle task, the first schedule, the idle
	// task picked again while it runs, strict level order, a queue filled to the brim and
	// an add dropped on it, then the ring pointer wrapping. Schedule rows carry junk in
	// the ignored fields on purpose.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{OP_SCHED, 8'h00, PRI_HIGH, 1'b1, '{ST_NONE,    8'h00, 1'b0, 1'b0}},
		'{OP_SCHED, 8'hFF, PRI_IDLE, 1'b1, '{ST_NONE,    8'h00, 1'b0, 1'b0}},
		'{OP_ADD,   8'hFF, PRI_IDLE, 1'b1, '{ST_IDLE,    8'h00, 1'b0, 1'b0}},
		'{OP_SCHED, 8'h00, PRI_HIGH, 1'b1, '{ST_SCHED,   8'hFF, 1'b1, 1'b1}},
		'{OP_SCHED, 8'h00, PRI_HIGH, 1'b1, '{ST_SCHED,   8'hFF, 1'b1, 1'b0}},
		'{OP_ADD,   8'h00, PRI_IDLE, 1'b1, '{ST_IDLE,    8'hFF, 1'b1, 1'b0}},
		'{OP_SCHED, 8'h00, PRI_HIGH, 1'b1, '{ST_SCHED,   8'h00, 1'b1, 1'b1}},
		'{OP_ADD,   8'hAA, PRI_LOW,  1'b1, '{ST_QUEUED,  8'h00, 1'b1, 1'b0}},
		'{OP_ADD,   8'h55, PRI_MED,  1'b1, '{ST_QUEUED,  8'h00, 1'b1, 1'b0}},
		'{OP_ADD,   8'h00, PRI_HIGH, 1'b1, '{ST_QUEUED,  8'h00, 1'b1, 1'b0}},
		'{OP_SCHED, 8'hFF, PRI_IDLE, 1'b1, '{ST_SCHED,   8'h00, 1'b1, 1'b0}},
		'{OP_SCHED, 8'h5A, PRI_LOW,  1'b1, '{ST_SCHED,   8'h55, 1'b1, 1'b1}},
		'{OP_SCHED, 8'h00, PRI_MED,  1'b1, '{ST_SCHED,   8'hAA, 1'b1, 1'b1}},
		'{OP_SCHED, 8'h00, PRI_HIGH, 1'b1, '{ST_SCHED,   8'h00, 1'b1, 1'b1}},
		'{OP_ADD,   8'hFF, PRI_HIGH, 1'b1, '{ST_QUEUED,  8'h00, 1'b1, 1'b0}},
		'{OP_ADD,   8'h01, PRI_HIGH, 1'b0, '0},
		'{OP_ADD,   8'h02, PRI_HIGH, 1'b0, '0},
		'{OP_ADD,   8'h04, PRI_HIGH, 1'b0, '0},
		'{OP_ADD,   8'h08, PRI_HIGH, 1'b0, '0},
		'{OP_ADD,   8'h10, PRI_HIGH, 1'b0, '0},
		'{OP_ADD,   8'h20, PRI_HIGH, 1'b0, '0},
		'{OP_ADD,   8'h40, PRI_HIGH, 1'b1, '{ST_QUEUED,  8'h00, 1'b1, 1'b0}},
		'{OP_ADD,   8'h77, PRI_HIGH, 1'b1, '{ST_DROPPED, 8'h00, 1'b1, 1'b0}},
		'{OP_SCHED, 8'h00, PRI_HIGH, 1'b1, '{ST_SCHED,   8'hFF, 1'b1, 1'b1}},
		'{OP_ADD,   8'h77, PRI_HIGH, 1'b0, '0}
	};

	// Advances the model by one request and returns the result it must produce.
	function automatic res_t schedule_step(logic op, logic [TASK_PORT_W-1:0] tid,
			logic [PRI_W-1:0] pri);
		res_t                   r;
		logic [TASK_PORT_W-1:0] id;
		logic [TASK_PORT_W-1:0] pick;
		logic                   found;
		int unsigned            lvl;

		id    = tid & TASK_PORT_W'((1 << TASK_ID_BITS) - 1);
		r     = '0;
		pick  = '0;
		found = 1'b0;
		if (op == OP_ADD) begin
			if (pri == PRI_IDLE) begin
				idle_task = id;
				idle_flag = 1'b1;
				r.status  = ST_IDLE;
			end else if (fifo_fill[pri] >= QUEUE_DEPTH) begin
				r.status = ST_DROPPED;
			end else begin
				ready_fifo[pri][(fifo_head[pri] + fifo_fill[pri]) % QUEUE_DEPTH] = id;
				fifo_fill[pri]++;
				r.status = ST_QUEUED;
			end
		end else begin
			// Highest non-empty level wins; the idle task is the last resort.
			for (lvl = 0; lvl < LEVELS; lvl++) begin
				if (!found && fifo_fill[lvl] != 0) begin
					pick           = ready_fifo[lvl][fifo_head[lvl]];
					fifo_head[lvl] = (fifo_head[lvl] + 1) % QUEUE_DEPTH;
					fifo_fill[lvl]--;
					found          = 1'b1;
				end
			end
			if (!found && idle_flag) begin
				pick  = idle_task;
				found = 1'b1;
			end
			if (found) begin
				r.switched = !run_flag || run_id != pick;
				run_id     = pick;
				run_flag   = 1'b1;
				r.status   = ST_SCHED;
			end else begin
				r.status = ST_NONE;
			end
		end
		r.running_task  = run_id;
		r.running_valid = run_flag;
		return r;
	endfunction

	task automatic note_mismatch(string what, res_t want, res_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s on result %0d: expected status %0d task %02h valid %0b sw %0b, got status %0d task %02h valid %0b sw %0b",
				$realtime, what, results_seen, want.status, want.running_task,
				want.running_valid, want.switched, got.status, got.running_task,
				got.running_valid, got.switched);
	endtask

	// Drives one request, with random idle cycles ahead of it, and returns in the time
	// step of its transfer with valid still high, so the next request can follow at once.
	task automatic send_request(logic op, logic [TASK_PORT_W-1:0] tid, logic [PRI_W-1:0] pri,
			logic typed, res_t exp);
		while ($urandom_range(99) < req_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.op           <= op;
		req_ch.task_id      <= tid;
		req_ch.priority_req <= pri;
		req_typed           <= typed;
		req_typed_res       <= exp;
		do
			@(posedge clk);
		while (!req_ch.ready);
		requests_sent++;
	endtask

	// Holds the request side off until every result owed so far has been seen.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (results_seen != requests_sent)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The receiver stalls at random with the rate the stimulus process picks.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// Monitor: every request transfer moves the model on by one step and queues the
	// result it owes; every result transfer is checked against the oldest one owed.
	// Both are sampled right at the clock edge, before any of the edge's updates land.
	always @(posedge clk) begin : monitor
		res_t want;
		res_t got;

		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				want = schedule_step(req_ch.op, req_ch.task_id, req_ch.priority_req);
				if (req_typed)
					want = req_typed_res;
				owed_results.push_back(want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status        = rsp_ch.status;
				got.running_task  = rsp_ch.running_task;
				got.running_valid = rsp_ch.running_valid;
				got.switched      = rsp_ch.switched;
				results_seen++;
				if (owed_results.size() == 0) begin
					note_mismatch("unexpected result", '0, got);
				end else begin
					want = owed_results.pop_front();
					if (got.status !== want.status || got.running_task !== want.running_task
							|| got.running_valid !== want.running_valid
							|| got.switched !== want.switched)
						note_mismatch("mismatch", want, got);
					case (want.status)
						ST_QUEUED:  cnt_queued++;
						ST_IDLE:    cnt_idle++;
						ST_DROPPED: cnt_dropped++;
						ST_SCHED:   cnt_sched++;
						default:    cnt_none++;
					endcase
					if (want.switched)
						cnt_switch++;
				end
			end
		end
	end

	// Stimulus: reset, the directed table, then four modes of random traffic with
	// different idling, each ending with a full drain of owed results.
	initial begin : stimulus
		int unsigned            burst_left;
		int unsigned            add_pct;
		int unsigned            roll;
		logic                   op;
		logic [TASK_PORT_W-1:0] tid;
		logic [PRI_W-1:0]       pri;

		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.op           = OP_ADD;
		req_ch.task_id      = '0;
		req_ch.priority_req = PRI_HIGH;
		req_typed           = 1'b0;
		req_typed_res       = '0;
		req_gap_pct         = 0;
		rsp_stall_pct       = 0;
		requests_sent       = 0;
		results_seen        = 0;
		mismatches          = 0;
		{cnt_queued, cnt_idle, cnt_dropped, cnt_sched, cnt_none, cnt_switch} = '0;
		burst_left          = 0;
		add_pct             = 50;

		// The model starts out as the scheduler does after reset.
		for (int l = 0; l < LEVELS; l++) begin
			fifo_head[l] = 0;
			fifo_fill[l] = 0;
		end
		run_id    = '0;
		run_flag  = 1'b0;
		idle_task = '0;
		idle_flag = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].op, dir_rows[i].task_id, dir_rows[i].pri,
				dir_rows[i].typed, dir_rows[i].exp);
		drain_results();

		// Mode 0 runs flat out, mode 1 idles the sender, mode 2 stalls the receiver and
		// mode 3 does a lighter mix of both.
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
				1: begin req_gap_pct = 70; rsp_stall_pct = 0;  end
				2: begin req_gap_pct = 0;  rsp_stall_pct = 70; end
				default: begin req_gap_pct = 24; rsp_stall_pct = 24; end
			endcase
			for (int n = 0; n < ITEMS_PER_MODE; n++) begin
				// Traffic comes in bursts that lean towards adds or schedules, so queues
				// both overflow and run dry, and the idle fallback gets its turn.
				if (burst_left == 0) begin
					burst_left = $urandom_range(30, 8);
					case ($urandom_range(2))
						0:       add_pct = 25;
						1:       add_pct = 55;
						default: add_pct = 85;
					endcase
				end
				burst_left--;
				op  = ($urandom_range(99) < add_pct) ? OP_ADD : OP_SCHED;
				tid = TASK_PORT_W'($urandom_range(255));
				roll = $urandom_range(19);
				if (roll == 0)
					pri = PRI_IDLE;
				else
					pri = PRI_W'($urandom_range(2));
				send_request(op, tid, pri, 1'b0, '0);
			end
			drain_results();
		end

		// Waiting on after the last drain catches any stray result beyond the last one owed.
		repeat (10) @(posedge clk);

		$display("Checked %0d results over %0d requests: %0d queued, %0d dropped on a full queue, %0d idle sets,",
			results_seen, requests_sent, cnt_queued, cnt_dropped, cnt_idle);
		$display("%0d schedules (%0d switching the running task), %0d with nothing runnable; %0d mismatches.",
			cnt_sched, cnt_switch, cnt_none, mismatches);
		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#1_000_000;
		$display("Timed out with %0d results still owed.", owed_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

FILE: priority_ready_queue_scheduler.f
+incdir+sv
sv/prqs_pkg.sv
sv/prqs_req_if.sv
sv/prqs_rsp_if.sv
sv/prqs_ready_mem.sv
sv/priority_ready_queue_scheduler.sv
tb/priority_ready_queue_scheduler_tb.sv
